>>> design/tgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and constants for the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

  localparam int SAMPLES_PER_TICK = 5;   // readings averaged per tick, 1..16
  localparam int NUM_FIELDS       = 5;   // sample fields carried by one tick
  localparam int SAMPLE_W         = 11;
  localparam int TIME_W           = 32;
  localparam int THR_W            = 11;
  localparam int MS_W             = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int SAMPLE_MAX       = (1 << SAMPLE_W) - 1;
  localparam int SUM_W            = $clog2(SAMPLES_PER_TICK * SAMPLE_MAX + 1);
  localparam int IN_DATA_W        = 88;  // 32 + 5 * 11 = 87, rounded to bytes
  localparam int OUT_DATA_W       = 8;

  localparam logic [THR_W-1:0] THR_RESET  = THR_W'(500);
  localparam logic [MS_W-1:0]  LONG_RESET = MS_W'(700);
  localparam logic [MS_W-1:0]  TAP_RESET  = MS_W'(300);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR_LEVEL     = 2'd0,
    REG_LONG_PRESS_MS = 2'd1,
    REG_TAP_WINDOW_MS = 2'd2
  } cfg_reg_t;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Merged tick handed to the gesture machine
  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              touched;
  } tgc_tick_t;

  // Result flags; touched lands in bit 0 when packed
  typedef struct packed {
    logic single_tap;
    logic double_tap;
    logic long_press_release;
    logic long_press_start;
    logic touched_now;
  } tgc_flags_t;

endpackage
`default_nettype wire

>>> design/tgc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_lane
// One sample lane: captures its charge-time reading when the pipe advances.
// ----------------------------------------------------------------------------
module tgc_lane (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire tgc_pkg::sample_t sample,
  output tgc_pkg::sample_t      sample_q
);
  import tgc_pkg::*;

  sample_t sample_r;

  always_ff @(posedge clk) begin
    if (load) begin
      sample_r <= sample;
    end
  end

  assign sample_q = sample_r;

endmodule
`default_nettype wire

>>> design/tgc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_merge
// Sums the lane readings and compares against the scaled threshold.
// ----------------------------------------------------------------------------
module tgc_merge (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         s_valid,
  output logic                              s_ready,
  input  wire tgc_pkg::sample_t             lane_q [tgc_pkg::SAMPLES_PER_TICK],
  input  wire logic [tgc_pkg::TIME_W-1:0]   now_ms,
  input  wire logic [tgc_pkg::THR_W-1:0]    thr_level,
  output logic                              m_valid,
  input  wire logic                         m_ready,
  output tgc_pkg::tgc_tick_t                m_tick
);
  import tgc_pkg::*;

  localparam logic [SUM_W-1:0] COUNT_W = SUM_W'(SAMPLES_PER_TICK);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] thr_scaled;
  logic             valid_r;
  tgc_tick_t        tick_r;
  tgc_tick_t        tick_nxt;
  logic             adv;

  // floor(sum / N) < thr  <=>  sum < thr * N
  always_comb begin
    sum = '0;
    for (int i = 0; i < SAMPLES_PER_TICK; i++) begin
      sum = sum + SUM_W'(lane_q[i]);
    end
  end

  assign thr_scaled = SUM_W'(SUM_W'(thr_level) * COUNT_W);
  assign tick_nxt   = {now_ms, (sum < thr_scaled)};

  assign adv     = !valid_r || m_ready;
  assign s_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_valid) begin
      tick_r <= tick_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_tick  = tick_r;

endmodule
`default_nettype wire

>>> design/tgc_gesture.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_gesture
// Press / tap state machine and result register.
// ----------------------------------------------------------------------------
module tgc_gesture (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       s_valid,
  output logic                            s_ready,
  input  wire tgc_pkg::tgc_tick_t         s_tick,
  input  wire logic [tgc_pkg::MS_W-1:0]   long_press_ms,
  input  wire logic [tgc_pkg::MS_W-1:0]   tap_window_ms,
  output logic                            m_valid,
  input  wire logic                       m_ready,
  output tgc_pkg::tgc_flags_t             m_flags
);
  import tgc_pkg::*;

  logic              was_pressed_r,     was_pressed_nxt;
  logic [TIME_W-1:0] press_start_r,     press_start_nxt;
  logic              long_shown_r,      long_shown_nxt;
  logic              awaiting_second_r, awaiting_second_nxt;
  logic              single_pending_r,  single_pending_nxt;
  logic [TIME_W-1:0] last_tap_r,        last_tap_nxt;
  logic              valid_r;
  tgc_flags_t        flags_r,           flags_nxt;
  logic              adv;
  logic              take;

  assign adv     = !valid_r || m_ready;
  assign s_ready = adv;
  assign take    = adv && s_valid;

  always_comb begin
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] tap_age;
    held    = s_tick.now_ms - press_start_r;
    tap_age = '0;

    was_pressed_nxt     = was_pressed_r;
    press_start_nxt     = press_start_r;
    long_shown_nxt      = long_shown_r;
    awaiting_second_nxt = awaiting_second_r;
    single_pending_nxt  = single_pending_r;
    last_tap_nxt        = last_tap_r;
    flags_nxt           = '0;
    flags_nxt.touched_now = s_tick.touched;

    if (s_tick.touched && !was_pressed_r) begin
      press_start_nxt = s_tick.now_ms;
      was_pressed_nxt = 1'b1;
      long_shown_nxt  = 1'b0;
    end

    if (!s_tick.touched && was_pressed_r) begin
      if (held >= TIME_W'(long_press_ms)) begin
        flags_nxt.long_press_release = 1'b1;
      end else if (awaiting_second_r) begin
        flags_nxt.double_tap = 1'b1;
        awaiting_second_nxt  = 1'b0;
        single_pending_nxt   = 1'b0;
      end else begin
        awaiting_second_nxt = 1'b1;
        single_pending_nxt  = 1'b1;
        last_tap_nxt        = s_tick.now_ms;
      end
      was_pressed_nxt = 1'b0;
    end

    // On the press tick was_pressed_r is still low, so only an ongoing press can fire
    if (s_tick.touched && was_pressed_r && !long_shown_r &&
        (held > TIME_W'(long_press_ms))) begin
      flags_nxt.long_press_start = 1'b1;
      long_shown_nxt             = 1'b1;
    end

    tap_age = s_tick.now_ms - last_tap_nxt;
    if (single_pending_nxt && (tap_age > TIME_W'(tap_window_ms))) begin
      flags_nxt.single_tap = 1'b1;
      single_pending_nxt   = 1'b0;
      awaiting_second_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r     <= 1'b0;
      press_start_r     <= '0;
      long_shown_r      <= 1'b0;
      awaiting_second_r <= 1'b0;
      single_pending_r  <= 1'b0;
      last_tap_r        <= '0;
      valid_r           <= 1'b0;
    end else begin
      if (take) begin
        was_pressed_r     <= was_pressed_nxt;
        press_start_r     <= press_start_nxt;
        long_shown_r      <= long_shown_nxt;
        awaiting_second_r <= awaiting_second_nxt;
        single_pending_r  <= single_pending_nxt;
        last_tap_r        <= last_tap_nxt;
      end
      if (adv) begin
        valid_r <= s_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      flags_r <= flags_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_flags = flags_r;

  a_start_needs_touch: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && flags_r.long_press_start |-> flags_r.touched_now)
    else $error("long press start without touch");

  a_release_untouched: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (flags_r.long_press_release || flags_r.double_tap)
      |-> !flags_r.touched_now)
    else $error("release event while touched");

  a_tap_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !(flags_r.double_tap && flags_r.single_tap))
    else $error("double and single tap together");

  a_pending_awaits: assert property (@(posedge clk) disable iff (!rst_n)
    single_pending_r |-> awaiting_second_r)
    else $error("single tap pending without awaiting second");

endmodule
`default_nettype wire

>>> design/touch_gesture_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An input transfer passes lane capture, sum and threshold compare, and
// gesture update into the output register, each registered in turn.
// Throughput: one tick per cycle while out_tready does not stall the output.
// Reset (rst_n, synchronous, active low) clears all valid bits and gesture
// state and returns the registers to threshold 500, long 700 ms, window 300 ms.
// ----------------------------------------------------------------------------
// touch_gesture_classifier_unit
// Averages capacitive readings per tick and flags long, double and single taps.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // now_ms[31:0], sample_a[42:32], sample_b[53:43], sample_c[64:54],
  // sample_d[75:65], sample_e[86:76], zero pad[87]
  input  wire logic [tgc_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // touched_now[0], long_press_start[1], long_press_release[2],
  // double_tap[3], single_tap[4], zero pad[7:5]
  output logic [tgc_pkg::OUT_DATA_W-1:0]           out_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [tgc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tgc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tgc_pkg::*;

  logic [THR_W-1:0]  thr_r;
  logic [MS_W-1:0]   long_r;
  logic [MS_W-1:0]   tap_r;

  sample_t           fields [NUM_FIELDS];
  sample_t           lane_q [SAMPLES_PER_TICK];
  logic [TIME_W-1:0] now_r;
  logic              valid_r;
  logic              adv;
  logic              load;
  logic              merge_ready;
  logic              tick_valid;
  tgc_tick_t         tick;
  logic              gest_ready;
  tgc_flags_t        flags;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      long_r <= LONG_RESET;
      tap_r  <= TAP_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THR_LEVEL:     thr_r  <= cfg_data[THR_W-1:0];
        REG_LONG_PRESS_MS: long_r <= cfg_data[MS_W-1:0];
        REG_TAP_WINDOW_MS: tap_r  <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_field
    assign fields[f] = in_tdata[TIME_W + f*SAMPLE_W +: SAMPLE_W];
  end

  assign adv       = !valid_r || merge_ready;
  assign in_tready = adv;
  assign load      = adv && in_tvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      now_r <= in_tdata[TIME_W-1:0];
    end
  end

  // Readings past the fifth reuse the fields in turn
  for (genvar i = 0; i < SAMPLES_PER_TICK; i++) begin : g_lane
    tgc_lane u_lane (
      .clk      (clk),
      .load     (load),
      .sample   (fields[i % NUM_FIELDS]),
      .sample_q (lane_q[i])
    );
  end

  tgc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (valid_r),
    .s_ready   (merge_ready),
    .lane_q    (lane_q),
    .now_ms    (now_r),
    .thr_level (thr_r),
    .m_valid   (tick_valid),
    .m_ready   (gest_ready),
    .m_tick    (tick)
  );

  tgc_gesture u_gesture (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_valid       (tick_valid),
    .s_ready       (gest_ready),
    .s_tick        (tick),
    .long_press_ms (long_r),
    .tap_window_ms (tap_r),
    .m_valid       (out_tvalid),
    .m_ready       (out_tready),
    .m_flags       (flags)
  );

  assign out_tdata = {(OUT_DATA_W - $bits(tgc_flags_t))'(0), flags};

endmodule
`default_nettype wire

>>> tb/tb_touch_gesture_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_gesture_classifier_unit
// Self-checking bench for the touch gesture classifier. A behavioral copy of
// the gesture machine predicts the flags of every accepted tick. A monitor
// compares each output transfer, field by field, with the oldest prediction.
// Directed tests cover field extremes, threshold edges, zero and maximum
// times, timestamp wrap and register writes. Random phases then replay press
// and release sequences under several register settings with bursty input,
// receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_touch_gesture_classifier_unit;
  import tgc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;   // no register here
  localparam int DRAIN_CYCLES = 4;                      // pipeline is 3 deep

  typedef logic [NUM_FIELDS-1:0][SAMPLE_W-1:0] samples_t;
  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // register mirror
  logic [THR_W-1:0]  touch_thr = THR_RESET;
  logic [MS_W-1:0]   long_ms   = LONG_RESET;
  logic [MS_W-1:0]   window_ms = TAP_RESET;

  // gesture state mirror
  logic              key_down      = 1'b0;
  logic [TIME_W-1:0] press_t0      = '0;
  logic              long_flagged  = 1'b0;
  logic              second_wanted = 1'b0;
  logic              tap_pending   = 1'b0;
  logic [TIME_W-1:0] tap_t0        = '0;

  tgc_flags_t        pending_flags[$];
  int                error_count = 0;

  bit                gapless     = 1'b0;
  int                burst_left  = 0;
  int                hold_cycles = 0;
  rx_mode_t          rx_mode     = RX_FREE;
  int                rx_left     = 0;
  int                rx_phase    = 0;
  logic [TIME_W-1:0] clock_ms    = '0;

  touch_gesture_classifier_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Gesture flags for one tick; advances the mirrored state.
  function automatic tgc_flags_t classify_tick(input logic [TIME_W-1:0] now,
                                               input samples_t smp);
    logic [31:0]       sum;
    logic [TIME_W-1:0] span;
    logic              touched;
    tgc_flags_t        f;
    sum = '0;
    for (int i = 0; i < SAMPLES_PER_TICK; i++) sum += 32'(smp[i % NUM_FIELDS]);
    touched = (sum / SAMPLES_PER_TICK) < 32'(touch_thr);
    f = '0;
    f.touched_now = touched;
    if (touched && !key_down) begin
      press_t0     = now;
      key_down     = 1'b1;
      long_flagged = 1'b0;
    end
    if (!touched && key_down) begin
      span = now - press_t0;
      if (span >= TIME_W'(long_ms)) begin
        f.long_press_release = 1'b1;
      end else if (second_wanted) begin
        f.double_tap  = 1'b1;
        second_wanted = 1'b0;
        tap_pending   = 1'b0;
      end else begin
        second_wanted = 1'b1;
        tap_pending   = 1'b1;
        tap_t0        = now;
      end
      key_down = 1'b0;
    end
    if (touched && key_down && !long_flagged) begin
      span = now - press_t0;
      if (span > TIME_W'(long_ms)) begin
        f.long_press_start = 1'b1;
        long_flagged       = 1'b1;
      end
    end
    span = now - tap_t0;
    if (tap_pending && span > TIME_W'(window_ms)) begin
      f.single_tap  = 1'b1;
      tap_pending   = 1'b0;
      second_wanted = 1'b0;
    end
    return f;
  endfunction

  function automatic samples_t flat(input int v);
    samples_t smp;
    for (int i = 0; i < NUM_FIELDS; i++) smp[i] = SAMPLE_W'(v);
    return smp;
  endfunction

  function automatic samples_t noise_samples();
    samples_t smp;
    for (int i = 0; i < NUM_FIELDS; i++) smp[i] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    return smp;
  endfunction

  // every reading at or above threshold, sometimes right on it
  function automatic samples_t release_samples();
    samples_t smp;
    if ($urandom_range(0, 7) == 0) return flat(touch_thr);
    for (int i = 0; i < NUM_FIELDS; i++)
      smp[i] = SAMPLE_W'($urandom_range(touch_thr, SAMPLE_MAX));
    return smp;
  endfunction

  // every reading below threshold, sometimes just below it (release readings if threshold is zero)
  function automatic samples_t touch_samples();
    samples_t smp;
    if (touch_thr == 0) return release_samples();
    if ($urandom_range(0, 7) == 0) return flat(touch_thr - 1);
    for (int i = 0; i < NUM_FIELDS; i++)
      smp[i] = SAMPLE_W'($urandom_range(0, touch_thr - 1));
    return smp;
  endfunction

  // time step, weighted toward the window and long press edges
  function automatic logic [TIME_W-1:0] next_delta();
    int unsigned span_max;
    int unsigned lo;
    span_max = ((long_ms > window_ms) ? long_ms : window_ms) + 8;
    lo       = (long_ms > 2) ? long_ms - 2 : 0;
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return $urandom_range(0, window_ms + 2);
      4, 5:    return $urandom_range(lo, long_ms + 2);
      6, 7, 8: return $urandom_range(0, span_max * 2);
      default: return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Output monitor: sampled mid-cycle, transfer completes at the next edge.
  always @(negedge clk) begin
    tgc_flags_t exp_f;
    tgc_flags_t got_f;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got_f = tgc_flags_t'(out_tdata[$bits(tgc_flags_t)-1:0]);
      if (pending_flags.size() == 0) begin
        $error("unexpected output transfer, tdata %0h", out_tdata);
        error_count++;
      end else begin
        exp_f = pending_flags.pop_front();
        check_field("touched_now", exp_f.touched_now, got_f.touched_now);
        check_field("long_press_start", exp_f.long_press_start, got_f.long_press_start);
        check_field("long_press_release", exp_f.long_press_release,
                    got_f.long_press_release);
        check_field("double_tap", exp_f.double_tap, got_f.double_tap);
        check_field("single_tap", exp_f.single_tap, got_f.single_tap);
        check_field("pad", '0, out_tdata[OUT_DATA_W-1:$bits(tgc_flags_t)]);
      end
    end
  end

  // Receiver: switches between free, random and periodic stalls; a long
  // hold-off takes priority.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 120);
      end
      rx_left  = rx_left - 1;
      rx_phase = rx_phase + 1;
      case (rx_mode)
        RX_FREE:   out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 2) != 0);
        default:   out_tready <= (rx_phase % 5) > 1;
      endcase
    end
  end

  // Called at a rising edge; returns at the edge of the transfer or after
  // the gap that follows a burst.
  task automatic send_tick(input logic [TIME_W-1:0] now, input samples_t smp);
    logic ready_seen;
    int   gap;
    in_tdata  <= {1'b0, smp[4], smp[3], smp[2], smp[1], smp[0], now};
    in_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    pending_flags.push_back(classify_tick(now, smp));
    if (!gapless) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(0, 6);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THR_LEVEL:     touch_thr = value[THR_W-1:0];
      REG_LONG_PRESS_MS: long_ms   = value;
      REG_TAP_WINDOW_MS: window_ms = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] thr,
                          input logic [CFG_DATA_W-1:0] lng,
                          input logic [CFG_DATA_W-1:0] win);
    write_reg(REG_THR_LEVEL, thr);
    write_reg(REG_LONG_PRESS_MS, lng);
    write_reg(REG_TAP_WINDOW_MS, win);
  endtask

  // Mostly press/release runs with random content, some pure noise.
  task automatic send_gesture_mix(input int count);
    int sent;
    int presses;
    int releases;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        clock_ms += next_delta();
        send_tick(clock_ms, noise_samples());
        sent++;
      end else begin
        presses  = $urandom_range(1, 4);
        releases = $urandom_range(1, 4);
        repeat (presses) begin
          clock_ms += next_delta();
          send_tick(clock_ms, touch_samples());
        end
        repeat (releases) begin
          clock_ms += next_delta();
          send_tick(clock_ms, release_samples());
        end
        sent += presses + releases;
      end
    end
  endtask

  // Reset values: taps, double tap, single tap timeout, long press, wrap.
  task automatic test_default_gestures();
    samples_t mixed;
    mixed = {11'd2047, 11'd0, 11'd0, 11'd0, 11'd448};   // average 499
    send_tick(32'h0000_0000, flat(SAMPLE_MAX));
    send_tick(32'hFFFF_FFFF, flat(0));
    send_tick(32'h0000_0100, mixed);                    // held across wrap
    send_tick(32'h0000_0200, flat(500));                // average on threshold
    send_tick(32'h0000_0250, flat(499));
    send_tick(32'h0000_0260, flat(SAMPLE_MAX));         // second short tap
    send_tick(32'h0000_1000, flat(0));
    send_tick(32'h0000_1010, flat(600));
    send_tick(32'h0000_113C, flat(SAMPLE_MAX));         // age equals window
    send_tick(32'h0000_113D, flat(SAMPLE_MAX));         // window lapsed
    send_tick(32'h0000_2000, flat(0));
    send_tick(32'h0000_22BC, flat(0));                  // held equals long
    send_tick(32'h0000_22BD, flat(0));
    send_tick(32'h0000_2500, flat(SAMPLE_MAX));
    send_tick(32'h0000_3000, flat(0));
    send_tick(32'h0000_32BC, flat(SAMPLE_MAX));         // release right at long
    drain();
  endtask

  task automatic test_zero_times();
    set_regs(CFG_DATA_W'(THR_RESET), 16'd0, 16'd0);
    send_tick(32'h0000_0010, flat(0));                  // no start on press tick
    send_tick(32'h0000_0011, flat(0));
    send_tick(32'h0000_0011, flat(SAMPLE_MAX));
    drain();
    set_regs(CFG_DATA_W'(THR_RESET), 16'hFFFF, 16'd0);
    send_tick(32'h0000_0020, flat(0));
    send_tick(32'h0000_0020, flat(SAMPLE_MAX));         // same time: no timeout
    send_tick(32'h0000_0021, flat(SAMPLE_MAX));
    send_tick(32'h0000_0100, flat(0));
    send_tick(32'h0001_00FF, flat(0));
    send_tick(32'h0001_0100, flat(0));
    send_tick(32'h0001_0200, flat(SAMPLE_MAX));
    drain();
  endtask

  task automatic test_threshold_extremes();
    set_regs(16'd0, LONG_RESET, TAP_RESET);
    send_tick(32'h0000_0500, flat(0));                  // nothing is below zero
    drain();
    write_reg(REG_THR_LEVEL, 16'd2047);
    send_tick(32'h0000_0600, flat(2046));
    send_tick(32'h0000_0610, flat(SAMPLE_MAX));
    drain();
    write_reg(REG_UNUSED, 16'h0001);                    // must leave threshold alone
    send_tick(32'h0000_0620, flat(2046));
    send_tick(32'h0000_0630, flat(SAMPLE_MAX));
    drain();
    write_reg(REG_THR_LEVEL, 16'hF803);                 // upper bits dropped
    send_tick(32'h0000_0700, flat(2));
    send_tick(32'h0000_0710, flat(3));
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_regs(CFG_DATA_W'(THR_RESET), LONG_RESET, TAP_RESET);
        1: set_regs(16'd2047, 16'd0, 16'd0);
        2: set_regs(16'd1, 16'hFFFF, 16'hFFFF);
        3: set_regs(16'd1024, 16'd20, 16'd5);
        default: set_regs(CFG_DATA_W'($urandom_range(0, SAMPLE_MAX)),
                          CFG_DATA_W'($urandom_range(0, 2000)),
                          CFG_DATA_W'($urandom_range(0, 1000)));
      endcase
      clock_ms = $urandom;
      send_gesture_mix(72);
      drain();
    end
  endtask

  // Output held off while input keeps coming: pipeline fills, in_tready drops.
  task automatic test_backpressure();
    set_regs(CFG_DATA_W'(THR_RESET), LONG_RESET, TAP_RESET);
    gapless     = 1'b1;
    hold_cycles = 200;
    send_gesture_mix(50);
    gapless = 1'b0;
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_gestures();
    test_zero_times();
    test_threshold_extremes();
    test_random_phases();
    test_backpressure();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
